/* rtl/bfml_pkg.sv */
package bfml_pkg;

  localparam int GRID         = 16;
  localparam int GRID_W       = $clog2(GRID);
  localparam int GLYPHS       = GRID * GRID;
  localparam int GLYPH_AW     = $clog2(GLYPHS);
  localparam int MAX_CELL_DEF = 64;
  localparam int ADDR_W       = 4;

  localparam logic [7:0]  BASE_GLYPH   = 8'd65;
  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [31:0] KEY_RESET    = 32'h0000_FFFF;
  localparam logic [6:0]  CELL_RESET   = 7'd16;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_START = 2'd1,
    OP_CHAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_KEY = 2'd0,
    REG_CW  = 2'd1,
    REG_CH  = 2'd2
  } reg_idx_e;

  typedef logic [6:0] cell_size_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        pixel;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         char_code;
  } item_t;

  typedef struct packed {
    logic       restart;
    cell_size_t top_init;
  } geom_upd_t;

  typedef struct packed {
    logic       font_ready;
    cell_size_t shared_top;
    cell_size_t base_row;
  } font_stat_t;

  typedef struct packed {
    logic [9:0] left;
    cell_size_t width;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

  typedef struct packed {
    logic                we;
    logic [GLYPH_AW-1:0] addr;
    glyph_t              data;
  } glyph_wr_t;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [9:0]         src_x;
    logic [10:0]        src_y;
    logic [6:0]         src_w;
    logic [6:0]         src_h;
  } result_t;

endpackage

/* rtl/bfml_in_if.sv */
interface bfml_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [31:0]        pixel;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         char_code;

  modport source (output valid, op, pixel, pos_x, pos_y, char_code, input ready);
  modport sink (input valid, op, pixel, pos_x, pos_y, char_code, output ready);
endinterface

/* rtl/bfml_out_if.sv */
interface bfml_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dest_x;
  logic signed [15:0] dest_y;
  logic [9:0]         src_x;
  logic [10:0]        src_y;
  logic [6:0]         src_w;
  logic [6:0]         src_h;

  modport source (output valid, dest_x, dest_y, src_x, src_y, src_w, src_h, input ready);
  modport sink (input valid, dest_x, dest_y, src_x, src_y, src_w, src_h, output ready);
endinterface

/* rtl/bfml_ram.sv */
module bfml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bfml_regs.sv */
module bfml_regs import bfml_pkg::*; #(
  parameter int MAX_CELL = MAX_CELL_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic [31:0]       key_o,
  output cell_size_t        cw_o,
  output cell_size_t        ch_o,
  output geom_upd_t         upd_o
);

  localparam cell_size_t MAX_SZ = cell_size_t'((MAX_CELL > 127) ? 127 : MAX_CELL);

  logic [31:0] key_q;
  cell_size_t  cw_q;
  cell_size_t  ch_q;
  logic        wr;
  reg_idx_e    idx;

  function automatic cell_size_t eff_size(input cell_size_t v);
    cell_size_t r;
    if (v == '0) begin
      r = cell_size_t'(1);
    end else if (v > MAX_SZ) begin
      r = MAX_SZ;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign wr  = psel_i && penable_i && pwrite_i;
  assign idx = reg_idx_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_RESET;
      cw_q  <= CELL_RESET;
      ch_q  <= CELL_RESET;
    end else if (wr) begin
      case (idx)
        REG_KEY: key_q <= pwdata_i;
        REG_CW:  cw_q  <= pwdata_i[6:0];
        REG_CH:  ch_q  <= pwdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY: prdata_o = key_q;
      REG_CW:  prdata_o = {25'd0, cw_q};
      REG_CH:  prdata_o = {25'd0, ch_q};
      default: prdata_o = '0;
    endcase
  end

  assign key_o = key_q;
  assign cw_o  = eff_size(cw_q);
  assign ch_o  = eff_size(ch_q);

  assign upd_o.restart  = wr && (idx == REG_CW || idx == REG_CH);
  assign upd_o.top_init = (idx == REG_CH) ? eff_size(pwdata_i[6:0]) : eff_size(ch_q);

endmodule

/* rtl/bfml_scan.sv */
module bfml_scan import bfml_pkg::*; #(
  parameter int MAX_CELL = MAX_CELL_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [31:0] pixel_i,
  input  logic [31:0] key_i,
  input  cell_size_t  cw_i,
  input  cell_size_t  ch_i,
  input  geom_upd_t   upd_i,
  output font_stat_t  stat_o,
  output glyph_wr_t   wr_o
);

  localparam int LW = (MAX_CELL > 2) ? $clog2(MAX_CELL) : 1;

  logic [LW-1:0]     lc_q, lr_q;
  logic [GRID_W-1:0] cc_q, band_q;
  logic [LW-1:0]     min_q [GRID];
  logic [LW-1:0]     max_q [GRID];
  logic [GRID-1:0]   found_q;
  cell_size_t        top_q, base_q;
  logic              ready_q;

  logic          start, ink, fnd, fnd_n, cell_end, row_last, row_end, done, sheet_last;
  logic [LW-1:0] mn, mx, mn_n, mx_n;
  cell_size_t    top_cur, base_cur, top_n, base_n, lr_sz;
  logic [10:0]   org;

  always_comb begin
    start    = (lc_q == '0) && (cc_q == '0) && (lr_q == '0) && (band_q == '0);
    top_cur  = start ? ch_i : top_q;
    base_cur = start ? ch_i : base_q;
    ink      = pixel_i != key_i;
    fnd      = found_q[cc_q];
    mn       = min_q[cc_q];
    mx       = max_q[cc_q];
    mn_n     = (ink && (!fnd || lc_q < mn)) ? lc_q : mn;
    mx_n     = (ink && (!fnd || lc_q > mx)) ? lc_q : mx;
    fnd_n    = fnd || ink;
    lr_sz    = cell_size_t'(lr_q);
    top_n    = (ink && lr_sz < top_cur) ? lr_sz : top_cur;
    base_n   = (ink && {band_q, cc_q} == BASE_GLYPH) ? lr_sz : base_cur;

    cell_end   = lc_q == LW'(cw_i - 7'd1);
    row_last   = lr_q == LW'(ch_i - 7'd1);
    row_end    = cell_end && (cc_q == GRID_W'(GRID - 1));
    done       = cell_end && row_last;
    sheet_last = row_end && row_last && (band_q == GRID_W'(GRID - 1));

    org = 11'(cc_q * cw_i);
    wr_o.we   = go_i && done;
    wr_o.addr = {band_q, cc_q};
    if (fnd_n) begin
      wr_o.data.left  = 10'(org + 11'(mn_n));
      wr_o.data.width = cell_size_t'(mx_n - mn_n) + cell_size_t'(1);
    end else begin
      wr_o.data.left  = 10'(org);
      wr_o.data.width = cw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q    <= '0;
      lr_q    <= '0;
      cc_q    <= '0;
      band_q  <= '0;
      ready_q <= 1'b0;
      top_q   <= CELL_RESET;
      base_q  <= CELL_RESET;
      found_q <= '0;
      for (int i = 0; i < GRID; i++) begin
        min_q[i] <= '1;
        max_q[i] <= '0;
      end
    end else if (upd_i.restart) begin
      lc_q    <= '0;
      lr_q    <= '0;
      cc_q    <= '0;
      band_q  <= '0;
      ready_q <= 1'b0;
      top_q   <= upd_i.top_init;
      base_q  <= upd_i.top_init;
      found_q <= '0;
      for (int i = 0; i < GRID; i++) begin
        min_q[i] <= '1;
        max_q[i] <= '0;
      end
    end else if (go_i) begin
      top_q  <= top_n;
      base_q <= base_n;
      if (done) begin
        found_q[cc_q] <= 1'b0;
        min_q[cc_q]   <= '1;
        max_q[cc_q]   <= '0;
      end else begin
        found_q[cc_q] <= fnd_n;
        min_q[cc_q]   <= mn_n;
        max_q[cc_q]   <= mx_n;
      end
      if (sheet_last) begin
        ready_q <= 1'b1;
      end else if (start) begin
        ready_q <= 1'b0;
      end
      if (cell_end) begin
        lc_q <= '0;
        cc_q <= cc_q + GRID_W'(1);
        if (row_end) begin
          if (row_last) begin
            lr_q   <= '0;
            band_q <= band_q + GRID_W'(1);
          end else begin
            lr_q <= lr_q + LW'(1);
          end
        end
      end else begin
        lc_q <= lc_q + LW'(1);
      end
    end
  end

  assign stat_o.font_ready = ready_q;
  assign stat_o.shared_top = top_q;
  assign stat_o.base_row   = base_q;

endmodule

/* rtl/bfml_layout.sv */
module bfml_layout import bfml_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  item_t      item_i,
  input  glyph_t     glyph_i,
  input  font_stat_t stat_i,
  input  cell_size_t cw_i,
  input  cell_size_t ch_i,
  output logic       has_res_o,
  output result_t    res_o
);

  logic [15:0] cur_x_q, cur_y_q, line_x_q;
  logic        char_ok, is_space, is_nl;

  always_comb begin
    char_ok   = (item_i.op == OP_CHAR) && stat_i.font_ready && (item_i.char_code != '0);
    is_space  = item_i.char_code == SPACE_CODE;
    is_nl     = item_i.char_code == NEWLINE_CODE;
    has_res_o = char_ok && !is_space && !is_nl;

    res_o.dest_x = cur_x_q;
    res_o.dest_y = cur_y_q;
    res_o.src_x  = glyph_i.left;
    res_o.src_y  = 11'(item_i.char_code[7:4] * ch_i) + 11'(stat_i.shared_top);
    res_o.src_w  = glyph_i.width;
    res_o.src_h  = ch_i - stat_i.shared_top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      line_x_q <= '0;
    end else if (go_i) begin
      case (item_i.op)
        OP_START: begin
          cur_x_q  <= item_i.pos_x;
          cur_y_q  <= item_i.pos_y;
          line_x_q <= item_i.pos_x;
        end
        OP_CHAR: begin
          if (char_ok) begin
            if (is_space) begin
              cur_x_q <= cur_x_q + 16'(cw_i >> 1);
            end else if (is_nl) begin
              cur_y_q <= cur_y_q + 16'(stat_i.base_row) - 16'(stat_i.shared_top);
              cur_x_q <= line_x_q;
            end else begin
              cur_x_q <= cur_x_q + 16'(glyph_i.width) + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/bitmap_font_metrics_and_layout.sv */
// Bitmap font glyph bounds and text layout. One item is accepted per clock unless a
// stalled output holds the input register. Pixel items (256 * cell_width * cell_height
// of them, raster order) build the glyph table; text items then yield one
// destination/source rectangle per printable character. An item waits in the input
// register while the glyph RAM is read, and its result is loaded into the output
// register when the item leaves it; the output register lets the next item in while a
// result waits. Writing cell_width or cell_height restarts the sheet load.
module bitmap_font_metrics_and_layout import bfml_pkg::*; #(
  parameter int MAX_CELL = MAX_CELL_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bfml_in_if.sink           in_i,
  bfml_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] key;
  cell_size_t  cw, ch;
  geom_upd_t   upd;
  font_stat_t  stat;
  glyph_wr_t   gwr;
  glyph_t      ram_rd, glyph;
  result_t     res, out_q;
  item_t       s1_q;
  logic        s1_v_q, out_v_q, byp_q;
  glyph_t      byp_data_q;
  logic        acc, s1_go, out_free, has_res;

  assign pready = 1'b1;

  bfml_regs #(.MAX_CELL(MAX_CELL)) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .key_o     (key),
    .cw_o      (cw),
    .ch_o      (ch),
    .upd_o     (upd)
  );

  assign out_free = !out_v_q || out_o.ready;
  assign s1_go    = s1_v_q && (!has_res || out_free);
  assign in_i.ready = !s1_v_q || s1_go;
  assign acc      = in_i.valid && in_i.ready;

  bfml_scan #(.MAX_CELL(MAX_CELL)) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (s1_go && s1_q.op == OP_PIXEL),
    .pixel_i (s1_q.pixel),
    .key_i   (key),
    .cw_i    (cw),
    .ch_i    (ch),
    .upd_i   (upd),
    .stat_o  (stat),
    .wr_o    (gwr)
  );

  bfml_ram #(.WIDTH(GLYPH_W), .DEPTH(GLYPHS)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (gwr.we),
    .waddr_i (gwr.addr),
    .wdata_i (gwr.data),
    .re_i    (acc),
    .raddr_i (in_i.char_code),
    .rdata_o (ram_rd)
  );

  // write and read of the same entry on one edge: take the new data
  assign glyph = byp_q ? byp_data_q : ram_rd;

  bfml_layout u_layout (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (s1_go),
    .item_i    (s1_q),
    .glyph_i   (glyph),
    .stat_i    (stat),
    .cw_i      (cw),
    .ch_i      (ch),
    .has_res_o (has_res),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_q <= 1'b1;
        byp_q  <= gwr.we && (gwr.addr == in_i.char_code);
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go && has_res) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q.op        <= in_i.op;
      s1_q.pixel     <= in_i.pixel;
      s1_q.pos_x     <= in_i.pos_x;
      s1_q.pos_y     <= in_i.pos_y;
      s1_q.char_code <= in_i.char_code;
      byp_data_q     <= gwr.data;
    end
    if (s1_go && has_res) begin
      out_q <= res;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.dest_x = out_q.dest_x;
  assign out_o.dest_y = out_q.dest_y;
  assign out_o.src_x  = out_q.src_x;
  assign out_o.src_y  = out_q.src_y;
  assign out_o.src_w  = out_q.src_w;
  assign out_o.src_h  = out_q.src_h;

endmodule

/* rtl/bfml_chk.sv */
module bfml_chk import bfml_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic [7:0]  in_char_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [66:0] out_data_i,
  input logic [6:0]  out_src_w_i
);

  logic [31:0] pend_q;
  logic        glyph_in, out_acc;

  // printable characters taken in, less results handed out
  assign glyph_in = in_valid_i && in_ready_i && (in_op_i == OP_CHAR) && (in_char_i != '0)
                    && (in_char_i != SPACE_CODE) && (in_char_i != NEWLINE_CODE);
  assign out_acc  = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (glyph_in && !out_acc) begin
      pend_q <= pend_q + 32'd1;
    end else if (!glyph_in && out_acc) begin
      pend_q <= pend_q - 32'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result without a pending glyph character");

  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_src_w_i != '0)
    else $error("glyph width of zero");

endmodule

bind bitmap_font_metrics_and_layout bfml_chk u_bfml_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .in_char_i   (in_i.char_code),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  ({out_o.dest_x, out_o.dest_y, out_o.src_x, out_o.src_y, out_o.src_w,
                 out_o.src_h}),
  .out_src_w_i (out_o.src_w)
);

/* tb/tb_bitmap_font_metrics_and_layout.sv */
module tb_bitmap_font_metrics_and_layout;
  timeunit 1ns;
  timeprecision 1ps;
  import bfml_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int TEXT_PER_PHASE = 60;
  localparam int PRE_LOAD_ROWS = 5;
  localparam int PARTIAL_MAX = 64;
  localparam int PHASES = 2;
  localparam int PH_CW [PHASES] = '{2, 0};
  localparam int PH_CH [PHASES] = '{0, 2};

  typedef struct {
    item_t   it;
    bit      typed;
    result_t rect;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  bfml_in_if  char_in ();
  bfml_out_if rect_out ();

  bitmap_font_metrics_and_layout dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (char_in),
    .out_o   (rect_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // font and layout state
  logic [31:0] key_val;
  logic [6:0]  cw_raw;
  logic [6:0]  ch_raw;
  logic [9:0]  gl_left [GLYPHS];
  logic [6:0]  gl_width [GLYPHS];
  int          bnd_lo [GRID];
  int          bnd_hi [GRID];
  bit          bnd_ink [GRID];
  int          px_col;
  int          px_row;
  int          top_row;
  int          base_line;
  bit          font_ok;
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic [15:0] line_x;

  result_t pending_rects [$];
  int      mismatches = 0;
  bit      steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int eff_cell(logic [6:0] v);
    if (v == 0) return 1;
    if (v > MAX_CELL_DEF) return MAX_CELL_DEF;
    return int'(v);
  endfunction

  function void bands_clear();
    for (int i = 0; i < GRID; i++) begin
      bnd_lo[i] = '1;
      bnd_hi[i] = 0;
      bnd_ink[i] = 1'b0;
    end
  endfunction

  function void sheet_restart();
    px_col = 0;
    px_row = 0;
    font_ok = 1'b0;
    top_row = eff_cell(ch_raw);
    base_line = top_row;
    bands_clear();
  endfunction

  function void font_reset();
    key_val = KEY_RESET;
    cw_raw = CELL_RESET;
    ch_raw = CELL_RESET;
    sheet_restart();
    cur_x = '0;
    cur_y = '0;
    line_x = '0;
  endfunction

  function void feed_pixel(logic [31:0] pix);
    int cw, ch, band, lr, cc, lc, g;
    cw = eff_cell(cw_raw);
    ch = eff_cell(ch_raw);
    if (px_col >= GRID * cw) px_col = 0;
    if (px_row >= GRID * ch) px_row = 0;
    if (px_col == 0 && px_row == 0) sheet_restart();
    band = px_row / ch;
    lr = px_row % ch;
    cc = px_col / cw;
    lc = px_col % cw;
    if (pix != key_val) begin
      if (!bnd_ink[cc] || lc < bnd_lo[cc]) bnd_lo[cc] = lc;
      if (!bnd_ink[cc] || lc > bnd_hi[cc]) bnd_hi[cc] = lc;
      bnd_ink[cc] = 1'b1;
      if (lr < top_row) top_row = lr;
      if (band * GRID + cc == int'(BASE_GLYPH)) base_line = lr;
    end
    px_col++;
    if (px_col == GRID * cw) begin
      px_col = 0;
      if (lr == ch - 1) begin
        for (int i = 0; i < GRID; i++) begin
          g = band * GRID + i;
          if (bnd_ink[i]) begin
            gl_left[g] = 10'(i * cw + bnd_lo[i]);
            gl_width[g] = 7'(bnd_hi[i] - bnd_lo[i] + 1);
          end else begin
            gl_left[g] = 10'(i * cw);
            gl_width[g] = 7'(cw);
          end
        end
        bands_clear();
      end
      px_row++;
      if (px_row == GRID * ch) begin
        px_row = 0;
        font_ok = 1'b1;
      end
    end
  endfunction

  function void reg_write(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_KEY: key_val = val;
      REG_CW: begin
        cw_raw = val[6:0];
        sheet_restart();
      end
      REG_CH: begin
        ch_raw = val[6:0];
        sheet_restart();
      end
      default: ;
    endcase
  endfunction

  function bit layout_step(input item_t it, output result_t r);
    int cw, ch;
    logic [7:0] c;
    r = '0;
    cw = eff_cell(cw_raw);
    ch = eff_cell(ch_raw);
    c = it.char_code;
    if (it.op == OP_PIXEL) begin
      feed_pixel(it.pixel);
      return 1'b0;
    end
    if (it.op == OP_START) begin
      cur_x = it.pos_x;
      cur_y = it.pos_y;
      line_x = cur_x;
      return 1'b0;
    end
    if (it.op != OP_CHAR || !font_ok || c == 0) return 1'b0;
    if (c == SPACE_CODE) begin
      cur_x = cur_x + 16'(cw / 2);
      return 1'b0;
    end
    if (c == NEWLINE_CODE) begin
      cur_y = cur_y + 16'(base_line - top_row);
      cur_x = line_x;
      return 1'b0;
    end
    r.dest_x = cur_x;
    r.dest_y = cur_y;
    r.src_x = gl_left[c];
    r.src_y = 11'((int'(c) / GRID) * ch + top_row);
    r.src_w = gl_width[c];
    r.src_h = 7'(ch - top_row);
    cur_x = cur_x + 16'(gl_width[c]) + 16'd1;
    return 1'b1;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.op = 2'($urandom);
    it.pixel = $urandom;
    it.pos_x = 16'($urandom);
    it.pos_y = 16'($urandom);
    it.char_code = 8'($urandom);
    return it;
  endfunction

  function automatic row_t row_of(logic [1:0] op, logic [15:0] px, logic [15:0] py,
                                  logic [7:0] code, bit typed, logic [15:0] dx,
                                  logic [15:0] dy, logic [9:0] sx, logic [10:0] sy,
                                  logic [6:0] sw, logic [6:0] sh);
    row_t r;
    r.it = noise_item();
    r.it.op = op;
    if (op == OP_START) begin
      r.it.pos_x = px;
      r.it.pos_y = py;
    end
    if (op == OP_CHAR) r.it.char_code = code;
    r.typed = typed;
    r.rect = '{dest_x: dx, dest_y: dy, src_x: sx, src_y: sy, src_w: sw, src_h: sh};
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input item_t it, input bit typed = 1'b0, input result_t rect = '0);
    int gap;
    bit hit;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      char_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_in.valid <= 1'b1;
    char_in.op <= it.op;
    char_in.pixel <= it.pixel;
    char_in.pos_x <= it.pos_x;
    char_in.pos_y <= it.pos_y;
    char_in.char_code <= it.char_code;
    do @(posedge clk_i); while (!char_in.ready);
    hit = layout_step(it, pred);
    if (typed) pending_rects = {pending_rects, rect};
    else if (hit) pending_rects = {pending_rects, pred};
  endtask

  task automatic settle();
    char_in.valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    reg_write(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // sheet positions are counted from (0,0)
  task automatic load_sheet(input int count, input int dens, input int margin,
                            input int blank_pct);
    int cw, ch, row, col, cell_idx;
    bit blank [GLYPHS];
    item_t it;
    cw = eff_cell(cw_raw);
    ch = eff_cell(ch_raw);
    foreach (blank[g]) blank[g] = ($urandom_range(99) < blank_pct);
    for (int k = 0; k < count; k++) begin
      row = k / (GRID * cw);
      col = k % (GRID * cw);
      cell_idx = (row / ch) * GRID + col / cw;
      it = noise_item();
      it.op = OP_PIXEL;
      if (!blank[cell_idx] && row % ch >= margin && $urandom_range(99) < dens) begin
        it.pixel = $urandom;
        if (it.pixel == key_val) it.pixel = ~key_val;
      end else begin
        it.pixel = key_val;
      end
      send_item(it);
    end
  endtask

  task automatic text_burst(input int n);
    int r;
    item_t it;
    for (int k = 0; k < n; k++) begin
      it = noise_item();
      r = $urandom_range(99);
      it.op = OP_CHAR;
      if (r < 10) begin
        it.op = OP_START;
        it.pos_x = pick_pos();
        it.pos_y = pick_pos();
      end else if (r < 25) begin
        it.char_code = SPACE_CODE;
      end else if (r < 33) begin
        it.char_code = NEWLINE_CODE;
      end else if (r < 37) begin
        it.char_code = 8'd0;
      end else if (r < 40) begin
        it.op = OP_UNUSED;
      end else begin
        it.char_code = 8'($urandom_range(1, 255));
      end
      send_item(it);
    end
  endtask

  initial begin : stall_gen
    int r;
    int hold;
    forever begin
      r = $urandom_range(99);
      if (steady || r < 70) begin
        rect_out.ready <= 1'b1;
        hold = $urandom_range(1, 8);
      end else if (r < 95) begin
        rect_out.ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        rect_out.ready <= 1'b0;
        hold = $urandom_range(10, 40);
      end
      repeat (hold) @(posedge clk_i);
    end
  end

  function void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : rect_check
    result_t want;
    if (rst_ni && rect_out.valid && rect_out.ready) begin
      if (pending_rects.size() == 0) begin
        $display("%0t: rect with none pending, dest %0h,%0h src %0h,%0h", $time,
                 rect_out.dest_x, rect_out.dest_y, rect_out.src_x, rect_out.src_y);
        mismatches++;
      end else begin
        want = pending_rects.pop_front();
        check_field("dest_x", want.dest_x, rect_out.dest_x);
        check_field("dest_y", want.dest_y, rect_out.dest_y);
        check_field("src_x", want.src_x, rect_out.src_x);
        check_field("src_y", want.src_y, rect_out.src_y);
        check_field("src_w", want.src_w, rect_out.src_w);
        check_field("src_h", want.src_h, rect_out.src_h);
      end
    end
  end

  initial begin : stimulus
    row_t rows [$];
    logic [31:0] key;
    int total, dens, margin, blank_pct;

    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    char_in.valid <= 1'b0;
    char_in.op <= OP_PIXEL;
    char_in.pixel <= '0;
    char_in.pos_x <= '0;
    char_in.pos_y <= '0;
    char_in.char_code <= '0;
    font_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // font not loaded yet: nothing may come out
    rows = {rows, row_of(OP_CHAR, 0, 0, BASE_GLYPH, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, 8'd255, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_START, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0)};
    // 1x1 cells, empty sheet: glyph n sits at column n%16, height zero
    rows = {rows, row_of(OP_START, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, 8'd255, 1, 16'h8000, 16'h7FFF, 15, 16, 1, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, BASE_GLYPH, 1, 16'h8002, 16'h7FFF, 1, 5, 1, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, SPACE_CODE, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, NEWLINE_CODE, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, 8'd1, 1, 16'h8000, 16'h7FFF, 1, 1, 1, 0)};
    rows = {rows, row_of(OP_START, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, 8'd16, 1, 16'h7FFF, 16'h8000, 0, 2, 1, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, 8'd0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    rows = {rows, row_of(OP_CHAR, 0, 0, 8'd66, 1, 16'h8001, 16'h8000, 2, 5, 1, 0)};

    for (int i = 0; i < PRE_LOAD_ROWS; i++) send_item(rows[i].it, rows[i].typed, rows[i].rect);
    settle();
    apb_write(REG_KEY, '1);
    apb_write(REG_CW, 32'd0);
    apb_write(REG_CH, 32'd0);
    load_sheet(GLYPHS, 0, 0, 0);
    for (int i = PRE_LOAD_ROWS; i < rows.size(); i++)
      send_item(rows[i].it, rows[i].typed, rows[i].rect);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      steady = ($urandom_range(3) == 0);
      key = (p == 0) ? 32'h0 : (p == 1) ? '1 : $urandom;
      apb_write(REG_KEY, key);
      apb_write(REG_CW, PH_CW[p]);
      apb_write(REG_CH, PH_CH[p]);
      if ($urandom_range(3) == 0) apb_write(REG_UNUSED, $urandom);
      total = GLYPHS * eff_cell(cw_raw) * eff_cell(ch_raw);
      case ($urandom_range(3))
        0: dens = 2;
        1: dens = 15;
        2: dens = 50;
        default: dens = 95;
      endcase
      margin = $urandom_range(0, eff_cell(ch_raw) - 1);
      blank_pct = $urandom_range(0, 40);
      if ($urandom_range(2) == 0) begin
        // abandon a partial load by rewriting the geometry
        load_sheet($urandom_range(1, PARTIAL_MAX), dens, margin, blank_pct);
        settle();
        apb_write(REG_CW, PH_CW[p]);
        text_burst(3);
      end
      load_sheet(total, dens, margin, blank_pct);
      text_burst(TEXT_PER_PHASE);
      if ($urandom_range(2) == 0) begin
        // a pixel after a full sheet begins a new load
        load_sheet(1, dens, margin, blank_pct);
        text_burst(4);
      end
    end

    steady = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
